// ===== sv/ppr_pkg.sv =====
// ----------------------------------------------------------------------------
// ppr_pkg
// Shared types and codes for the pipe pool ring buffer block.
// ----------------------------------------------------------------------------
package ppr_pkg;

    typedef enum logic [2:0] {
        OP_ALLOC       = 3'd0,
        OP_ADD_READER  = 3'd1,
        OP_ADD_WRITER  = 3'd2,
        OP_CLOSE_READ  = 3'd3,
        OP_CLOSE_WRITE = 3'd4,
        OP_WRITE_BYTE  = 3'd5,
        OP_READ_BYTE   = 3'd6,
        OP_QUERY       = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_FULL    = 2'd1,
        STAT_EMPTY   = 2'd2,
        STAT_NO_FREE = 2'd3
    } status_t;

    localparam logic [7:0] REF_MAX = 8'd255;

    typedef struct packed {
        op_t        req_type;
        logic [2:0] pipe_id;
        logic [7:0] write_data;
        logic       transfer_last;
    } req_t;

    typedef struct packed {
        status_t    status;
        logic [2:0] alloc_id;
        logic [7:0] read_data;
        logic       is_empty;
        logic [7:0] reader_refs;
        logic [7:0] writer_refs;
        logic       in_use;
        logic       last_echo;
    } resp_t;

    typedef struct packed {
        logic load;
        logic exec;
    } ctrl_cmd_t;

endpackage

// ===== sv/ppr_ctrl.sv =====
// ----------------------------------------------------------------------------
// ppr_ctrl
// Request sequencer: accept, execute, then hold the response until taken.
// ----------------------------------------------------------------------------
module ppr_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    output logic               resp_valid,
    input  logic               resp_ready,
    output ppr_pkg::ctrl_cmd_t cmd
);
    import ppr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_RESP = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (resp_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_ready  = (state_reg == ST_IDLE);
    assign resp_valid = (state_reg == ST_RESP);
    assign cmd.load   = (state_reg == ST_IDLE) && req_valid;
    assign cmd.exec   = (state_reg == ST_EXEC);

endmodule

// ===== sv/ppr_datapath.sv =====
// ----------------------------------------------------------------------------
// ppr_datapath
// Per-pipe pointers, reference counts, free-pipe encoder and byte memory.
// ----------------------------------------------------------------------------
module ppr_datapath #(
    parameter int NUM_PIPES  = 8,
    parameter int PIPE_DEPTH = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ppr_pkg::ctrl_cmd_t cmd,
    input  ppr_pkg::req_t      req,
    output ppr_pkg::resp_t     resp
);
    import ppr_pkg::*;

    localparam int PW = (NUM_PIPES > 1) ? $clog2(NUM_PIPES) : 1;
    localparam int AW = $clog2(PIPE_DEPTH);
    localparam int MEM_DEPTH = NUM_PIPES * PIPE_DEPTH;

    req_t                 req_reg;
    logic [NUM_PIPES-1:0] used_reg;
    logic [AW-1:0]        rptr_reg [NUM_PIPES];
    logic [AW-1:0]        wptr_reg [NUM_PIPES];
    logic [7:0]           rcnt_reg [NUM_PIPES];
    logic [7:0]           wcnt_reg [NUM_PIPES];

    logic [7:0]           mem [MEM_DEPTH];
    logic [7:0]           mem_q_reg;

    status_t              status_reg;
    logic [2:0]           alloc_id_reg;
    logic                 empty_reg;
    logic [7:0]           rrefs_reg;
    logic [7:0]           wrefs_reg;
    logic                 inuse_reg;
    logic                 last_reg;
    logic                 rd_sel_reg;

    logic                 free_found;
    logic [PW-1:0]        free_idx;
    logic [PW-1:0]        pidx;
    logic                 in_range;
    logic [AW-1:0]        rp;
    logic [AW-1:0]        wp;
    logic [AW-1:0]        rp_n;
    logic [AW-1:0]        wp_n;
    logic [7:0]           rc;
    logic [7:0]           wc;
    logic [7:0]           rc_n;
    logic [7:0]           wc_n;
    logic                 used_n;
    status_t              stat_n;
    logic                 mem_we;
    logic                 mem_re;

    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = NUM_PIPES - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = PW'(i);
            end
        end
    end

    assign pidx     = PW'(req_reg.pipe_id);
    assign in_range = (32'(req_reg.pipe_id) < NUM_PIPES);
    assign rp       = rptr_reg[pidx];
    assign wp       = wptr_reg[pidx];
    assign rc       = rcnt_reg[pidx];
    assign wc       = wcnt_reg[pidx];

    always_comb
    begin
        rp_n   = rp;
        wp_n   = wp;
        rc_n   = rc;
        wc_n   = wc;
        used_n = used_reg[pidx];
        stat_n = STAT_OK;
        mem_we = 1'b0;
        mem_re = 1'b0;
        case (req_reg.req_type)
            OP_ADD_READER:
            begin
                rc_n = (rc == REF_MAX) ? rc : rc + 8'd1;
            end
            OP_ADD_WRITER:
            begin
                wc_n = (wc == REF_MAX) ? wc : wc + 8'd1;
            end
            OP_CLOSE_READ:
            begin
                rc_n = (rc == 8'd0) ? rc : rc - 8'd1;
                if (rc_n == 8'd0 && wc == 8'd0)
                begin
                    used_n = 1'b0;
                end
            end
            OP_CLOSE_WRITE:
            begin
                wc_n = (wc == 8'd0) ? wc : wc - 8'd1;
                if (rc == 8'd0 && wc_n == 8'd0)
                begin
                    used_n = 1'b0;
                end
            end
            OP_WRITE_BYTE:
            begin
                if (wp + AW'(1) == rp)
                begin
                    stat_n = STAT_FULL;
                end
                else
                begin
                    wp_n   = wp + AW'(1);
                    mem_we = in_range;
                end
            end
            OP_READ_BYTE:
            begin
                if (rp == wp)
                begin
                    stat_n = STAT_EMPTY;
                end
                else
                begin
                    rp_n   = rp + AW'(1);
                    mem_re = in_range;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req;
        end
        if (cmd.exec && mem_we)
        begin
            mem[{pidx, wp}] <= req_reg.write_data;
        end
        if (cmd.exec && mem_re)
        begin
            mem_q_reg <= mem[{pidx, rp}];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
            for (int i = 0; i < NUM_PIPES; i++)
            begin
                rptr_reg[i] <= '0;
                wptr_reg[i] <= '0;
                rcnt_reg[i] <= '0;
                wcnt_reg[i] <= '0;
            end
        end
        else if (cmd.exec)
        begin
            if (req_reg.req_type == OP_ALLOC)
            begin
                if (free_found)
                begin
                    used_reg[free_idx] <= 1'b1;
                    rptr_reg[free_idx] <= '0;
                    wptr_reg[free_idx] <= '0;
                    rcnt_reg[free_idx] <= 8'd1;
                    wcnt_reg[free_idx] <= 8'd1;
                end
            end
            else if (in_range)
            begin
                used_reg[pidx] <= used_n;
                rptr_reg[pidx] <= rp_n;
                wptr_reg[pidx] <= wp_n;
                rcnt_reg[pidx] <= rc_n;
                wcnt_reg[pidx] <= wc_n;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            last_reg <= req_reg.transfer_last;
            if (req_reg.req_type == OP_ALLOC)
            begin
                rd_sel_reg   <= 1'b0;
                status_reg   <= free_found ? STAT_OK : STAT_NO_FREE;
                alloc_id_reg <= free_found ? 3'(free_idx) : 3'd0;
                empty_reg    <= free_found;
                rrefs_reg    <= free_found ? 8'd1 : 8'd0;
                wrefs_reg    <= free_found ? 8'd1 : 8'd0;
                inuse_reg    <= free_found;
            end
            else if (!in_range)
            begin
                rd_sel_reg   <= 1'b0;
                status_reg   <= STAT_OK;
                alloc_id_reg <= 3'd0;
                empty_reg    <= 1'b1;
                rrefs_reg    <= 8'd0;
                wrefs_reg    <= 8'd0;
                inuse_reg    <= 1'b0;
            end
            else
            begin
                rd_sel_reg   <= mem_re;
                status_reg   <= stat_n;
                alloc_id_reg <= 3'd0;
                empty_reg    <= (rp_n == wp_n);
                rrefs_reg    <= rc_n;
                wrefs_reg    <= wc_n;
                inuse_reg    <= used_n;
            end
        end
    end

    assign resp.status      = status_reg;
    assign resp.alloc_id    = alloc_id_reg;
    assign resp.read_data   = rd_sel_reg ? mem_q_reg : 8'd0;
    assign resp.is_empty    = empty_reg;
    assign resp.reader_refs = rrefs_reg;
    assign resp.writer_refs = wrefs_reg;
    assign resp.in_use      = inuse_reg;
    assign resp.last_echo   = last_reg;

endmodule

// ===== sv/pipe_pool_ring_buffers.sv =====
// ----------------------------------------------------------------------------
// pipe_pool_ring_buffers
// Pool of byte pipes, each a ring buffer with read and write reference counts.
//
//   Channel  Signals                      Payload
//   req      req_valid / req_ready        req_t  (type, pipe, byte, last)
//   resp     resp_valid / resp_ready      resp_t (status, ids, byte, counts)
//
// Each request passes through accept, execute and deliver, in the order set by
// the controller sequence and the registered read of the byte memory. Reset
// clears all pointers, counts and pipe flags at once; the byte memory is not
// cleared. req_ready stays low from acceptance until the response transaction
// completes, and a response holds while resp_ready is low.
// ----------------------------------------------------------------------------
module pipe_pool_ring_buffers #(
    parameter int NUM_PIPES  = 8,
    parameter int PIPE_DEPTH = 256
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  ppr_pkg::req_t  req,
    output logic           resp_valid,
    input  logic           resp_ready,
    output ppr_pkg::resp_t resp
);
    import ppr_pkg::*;

    ctrl_cmd_t cmd;

    ppr_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .resp_valid (resp_valid),
        .resp_ready (resp_ready),
        .cmd        (cmd)
    );

    ppr_datapath #(
        .NUM_PIPES  (NUM_PIPES),
        .PIPE_DEPTH (PIPE_DEPTH)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .req   (req),
        .resp  (resp)
    );

    a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(req_ready && resp_valid))
        else $error("Request accepted while a response is pending.");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> (!req_ready ##1 resp_valid))
        else $error("Accepted request did not produce a response in sequence.");

    a_no_free: assert property (@(posedge clk) disable iff (!rst_n)
        (resp_valid && resp.status == STAT_NO_FREE) |->
            (!resp.in_use && resp.reader_refs == 8'd0 && resp.alloc_id == 3'd0))
        else $error("Exhausted alloc reported pipe fields.");

    a_empty_read: assert property (@(posedge clk) disable iff (!rst_n)
        (resp_valid && resp.status == STAT_EMPTY) |->
            (resp.is_empty && resp.read_data == 8'd0))
        else $error("Empty read returned data or a non-empty pipe.");

endmodule

// ===== tb/pipe_pool_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pipe_pool_checker
// Watches both channels of the pipe pool, predicts each response from its own
// copy of the pipe pointers, reference counts and byte contents, and compares
// every response transaction field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module pipe_pool_checker #(
    parameter int NUM_PIPES  = 8,
    parameter int PIPE_DEPTH = 256
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    input  logic           req_ready,
    input  ppr_pkg::req_t  req,
    input  logic           resp_valid,
    input  logic           resp_ready,
    input  ppr_pkg::resp_t resp,
    output int             fail_count,
    output int             pending
);
    import ppr_pkg::*;

    localparam int PTR_W = $clog2(PIPE_DEPTH);

    logic             used_q    [NUM_PIPES];
    logic [PTR_W-1:0] rd_ptr    [NUM_PIPES];
    logic [PTR_W-1:0] wr_ptr    [NUM_PIPES];
    logic [7:0]       rd_refs   [NUM_PIPES];
    logic [7:0]       wr_refs   [NUM_PIPES];
    logic [7:0]       pipe_bytes[NUM_PIPES][PIPE_DEPTH];

    resp_t expected_resps[$];
    resp_t want;
    int    mismatches = 0;
    int    outstanding = 0;

    assign fail_count = mismatches;
    assign pending    = outstanding;

    function automatic resp_t predict_response(input req_t r);
        resp_t            rsp;
        int               p;
        logic [PTR_W-1:0] nxt;
        rsp           = '0;
        rsp.status    = STAT_OK;
        rsp.last_echo = r.transfer_last;
        if (r.req_type == OP_ALLOC)
        begin
            p = -1;
            for (int i = NUM_PIPES - 1; i >= 0; i--)
            begin
                if (!used_q[i])
                begin
                    p = i;
                end
            end
            if (p < 0)
            begin
                rsp.status = STAT_NO_FREE;
                return rsp;
            end
            rd_ptr[p]    = '0;
            wr_ptr[p]    = '0;
            rd_refs[p]   = 8'd1;
            wr_refs[p]   = 8'd1;
            used_q[p]    = 1'b1;
            rsp.alloc_id = p[2:0];
        end
        else if (int'(r.pipe_id) >= NUM_PIPES)
        begin
            rsp.is_empty = 1'b1;
            return rsp;
        end
        else
        begin
            p = int'(r.pipe_id);
            case (r.req_type)
                OP_ADD_READER:
                begin
                    if (rd_refs[p] != REF_MAX) rd_refs[p]++;
                end
                OP_ADD_WRITER:
                begin
                    if (wr_refs[p] != REF_MAX) wr_refs[p]++;
                end
                OP_CLOSE_READ, OP_CLOSE_WRITE:
                begin
                    if (r.req_type == OP_CLOSE_READ && rd_refs[p] != 0) rd_refs[p]--;
                    if (r.req_type == OP_CLOSE_WRITE && wr_refs[p] != 0) wr_refs[p]--;
                    if (rd_refs[p] == 0 && wr_refs[p] == 0) used_q[p] = 1'b0;
                end
                OP_WRITE_BYTE:
                begin
                    nxt = wr_ptr[p] + 1'b1;
                    if (nxt == rd_ptr[p])
                    begin
                        rsp.status = STAT_FULL;
                    end
                    else
                    begin
                        pipe_bytes[p][wr_ptr[p]] = r.write_data;
                        wr_ptr[p] = nxt;
                    end
                end
                OP_READ_BYTE:
                begin
                    if (rd_ptr[p] == wr_ptr[p])
                    begin
                        rsp.status = STAT_EMPTY;
                    end
                    else
                    begin
                        rsp.read_data = pipe_bytes[p][rd_ptr[p]];
                        rd_ptr[p] = rd_ptr[p] + 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
        rsp.is_empty    = (rd_ptr[p] == wr_ptr[p]);
        rsp.reader_refs = rd_refs[p];
        rsp.writer_refs = wr_refs[p];
        rsp.in_use      = used_q[p];
        return rsp;
    endfunction

    task automatic check_field(input string name, input int unsigned exp_val,
                               input int unsigned act_val);
        if (exp_val != act_val)
        begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, name, exp_val, act_val);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_PIPES; i++)
            begin
                used_q[i]  = 1'b0;
                rd_ptr[i]  = '0;
                wr_ptr[i]  = '0;
                rd_refs[i] = '0;
                wr_refs[i] = '0;
                for (int j = 0; j < PIPE_DEPTH; j++)
                begin
                    pipe_bytes[i][j] = '0;
                end
            end
            expected_resps.delete();
        end
        else
        begin
            if (resp_valid && resp_ready)
            begin
                if (expected_resps.size() == 0)
                begin
                    mismatches++;
                    $display("%0t ns: unexpected response, expected none, actual %h",
                             $time, resp);
                end
                else
                begin
                    want = expected_resps.pop_front();
                    check_field("status", want.status, resp.status);
                    check_field("alloc_id", want.alloc_id, resp.alloc_id);
                    check_field("read_data", want.read_data, resp.read_data);
                    check_field("is_empty", want.is_empty, resp.is_empty);
                    check_field("reader_refs", want.reader_refs, resp.reader_refs);
                    check_field("writer_refs", want.writer_refs, resp.writer_refs);
                    check_field("in_use", want.in_use, resp.in_use);
                    check_field("last_echo", want.last_echo, resp.last_echo);
                end
            end
            if (req_valid && req_ready)
            begin
                expected_resps.push_back(predict_response(req));
            end
        end
        outstanding = expected_resps.size();
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the pipe pool with directed and random request transactions under
// several sender and receiver idling patterns, including one long receiver
// hold-off, and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_top;
    import ppr_pkg::*;

    localparam int PIPE_DEPTH     = 256;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 400;
    localparam int PHASE_ITEMS    = 110;

    logic  clk;
    logic  rst_n;
    logic  req_valid;
    logic  req_ready;
    req_t  req;
    logic  resp_valid;
    logic  resp_ready;
    resp_t resp;
    int    fail_count;
    int    pending;

    int    send_idle_pct  = 0;
    int    recv_stall_pct = 0;
    bit    hold_request   = 1'b0;
    int    sent_items     = 0;

    pipe_pool_ring_buffers dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .resp_valid (resp_valid),
        .resp_ready (resp_ready),
        .resp       (resp)
    );

    pipe_pool_checker pool_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .resp_valid (resp_valid),
        .resp_ready (resp_ready),
        .resp       (resp),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        rst_n      = 1'b0;
        req_valid  = 1'b0;
        req        = '0;
        resp_ready = 1'b0;
    end

    task automatic send_req(input op_t op, input logic [2:0] pipe,
                            input logic [7:0] data, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req       <= '{req_type: op, pipe_id: pipe, write_data: data, transfer_last: last};
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        sent_items++;
    endtask

    function automatic logic [2:0] pick_pipe();
        if ($urandom_range(0, 99) < 75) return 3'($urandom_range(0, 3));
        return 3'($urandom_range(0, 7));
    endfunction

    task automatic byte_run(input op_t op, input logic [2:0] pipe, input int len);
        for (int i = 0; i < len; i++)
        begin
            send_req(op, pipe, 8'($urandom_range(0, 255)), i == len - 1);
        end
    endtask

    task automatic random_sequence();
        int         kind;
        logic [2:0] pipe;
        op_t        op;
        kind = $urandom_range(0, 99);
        pipe = pick_pipe();
        if (kind < 35)
        begin
            byte_run(OP_WRITE_BYTE, pipe, $urandom_range(1, 12));
        end
        else if (kind < 65)
        begin
            byte_run(OP_READ_BYTE, pipe, $urandom_range(1, 12));
        end
        else if (kind < 85)
        begin
            op = ($urandom_range(0, 5) == 5) ? OP_QUERY : op_t'($urandom_range(0, 4));
            send_req(op, pipe, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
        else
        begin
            send_req(op_t'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                     8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
    endtask

    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                resp_ready <= 1'b0;
            end
            else
            begin
                resp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((req_valid && req_ready) || (resp_valid && resp_ready)) quiet = 0;
            else quiet++;
            if (quiet >= WATCHDOG_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int         phase_start;
        logic [2:0] pipe;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: exhaust the pool, byte traffic, empty read, freeing,
        // close on a zero count and reallocation of the freed pipe.
        repeat (9) send_req(OP_ALLOC, 3'd5, 8'h00, 1'b0);
        send_req(OP_ADD_READER, 3'd0, 8'hFF, 1'b1);
        send_req(OP_ADD_WRITER, 3'd0, 8'h00, 1'b0);
        send_req(OP_WRITE_BYTE, 3'd0, 8'h00, 1'b0);
        send_req(OP_WRITE_BYTE, 3'd0, 8'hFF, 1'b1);
        send_req(OP_READ_BYTE, 3'd0, 8'h00, 1'b0);
        send_req(OP_READ_BYTE, 3'd0, 8'h00, 1'b1);
        send_req(OP_READ_BYTE, 3'd0, 8'hFF, 1'b0);
        send_req(OP_QUERY, 3'd0, 8'h00, 1'b0);
        send_req(OP_CLOSE_READ, 3'd7, 8'h00, 1'b0);
        send_req(OP_CLOSE_WRITE, 3'd7, 8'hFF, 1'b1);
        send_req(OP_CLOSE_READ, 3'd7, 8'h00, 1'b0);
        send_req(OP_QUERY, 3'd7, 8'hFF, 1'b1);
        send_req(OP_ALLOC, 3'd0, 8'h00, 1'b1);

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 45;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 45;
                end
                default:
                begin
                    send_idle_pct  = 13;
                    recv_stall_pct = 13;
                end
            endcase
            pipe = pick_pipe();
            case (ph)
                0:
                begin
                    byte_run(OP_WRITE_BYTE, pipe, PIPE_DEPTH + 2);
                    byte_run(OP_READ_BYTE, pipe, PIPE_DEPTH + 1);
                end
                1: byte_run(OP_ADD_READER, pipe, 257);
                2:
                begin
                    hold_request = 1'b1;
                    byte_run(OP_ADD_WRITER, pipe, 257);
                end
                default:
                begin
                end
            endcase
            phase_start = sent_items;
            while (sent_items - phase_start < PHASE_ITEMS) random_sequence();
        end

        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
